// ----- rtl/sbrb_pkg.sv -----
// sbrb_pkg: shared constants and types for the sample block ring buffer.
// No dependencies; imported by every module of the block.

package sbrb_pkg;

    localparam int DEF_BLOCK_WORDS = 32;
    localparam int DEF_NUM_BLOCKS  = 4;
    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 6;
    localparam int LOST_W          = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [LOST_W-1:0] LOST_MAX = 16'hFFFF;

    typedef enum logic [0:0]
    {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

endpackage

// ----- rtl/sample_block_ring_buffer.sv -----
// sample_block_ring_buffer: top level, front end, drain queue and back end.
// Depends on sbrb_pkg, sbrb_front, sbrb_cmd_fifo, sbrb_back.

// A push is taken every cycle. The one exception is a push that must start a
// new block while the only block it could use is still being read out: it
// waits until the final word of that block has left the sample memory. A
// drain of a full block yields BLOCK_WORDS transfers, one per cycle unless
// stalled, set by the single read port of the sample memory; a drain with
// nothing full yields one transfer. Up to two drain commands wait in a queue,
// so commands keep being taken while results stream out or are stalled.

module sample_block_ring_buffer #(
    parameter int BLOCK_WORDS = sbrb_pkg::DEF_BLOCK_WORDS,
    parameter int NUM_BLOCKS  = sbrb_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic                          op,
    input  logic [sbrb_pkg::SAMPLE_W-1:0] sample,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [sbrb_pkg::SAMPLE_W-1:0] word,
    output logic [sbrb_pkg::COUNT_W-1:0]  word_count,
    output logic [sbrb_pkg::LOST_W-1:0]   lost_samples,
    output logic                          empty_res,
    output logic                          last
);
    import sbrb_pkg::*;

    localparam int BI_W = $clog2(NUM_BLOCKS);
    localparam int WI_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    logic                  swr_en;
    logic [BI_W+WI_W-1:0]  swr_addr;
    logic [SAMPLE_W-1:0]   swr_data;
    logic                  lwr_en;
    logic [BI_W-1:0]       lwr_addr;
    logic [LOST_W-1:0]     lwr_data;
    logic                  q_push, q_empty_in, q_full, q_pop, q_nonempty;
    logic [BI_W-1:0]       q_blk_in;
    logic [BI_W:0]         q_head;
    logic                  blk_free;

    sbrb_front #(
        .BLOCK_WORDS (BLOCK_WORDS),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .op        (op_t'(op)),
        .sample    (sample),
        .swr_en    (swr_en),
        .swr_addr  (swr_addr),
        .swr_data  (swr_data),
        .lwr_en    (lwr_en),
        .lwr_addr  (lwr_addr),
        .lwr_data  (lwr_data),
        .q_push    (q_push),
        .q_empty   (q_empty_in),
        .q_blk     (q_blk_in),
        .q_full    (q_full),
        .blk_free  (blk_free)
    );

    sbrb_cmd_fifo #(
        .DATA_W (BI_W + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({q_empty_in, q_blk_in}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .nonempty  (q_nonempty)
    );

    sbrb_back #(
        .BLOCK_WORDS (BLOCK_WORDS),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .swr_en       (swr_en),
        .swr_addr     (swr_addr),
        .swr_data     (swr_data),
        .lwr_en       (lwr_en),
        .lwr_addr     (lwr_addr),
        .lwr_data     (lwr_data),
        .q_nonempty   (q_nonempty),
        .q_empty      (q_head[BI_W]),
        .q_blk        (q_head[BI_W-1:0]),
        .q_pop        (q_pop),
        .blk_free     (blk_free),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .word         (word),
        .word_count   (word_count),
        .lost_samples (lost_samples),
        .empty_res    (empty_res),
        .last         (last)
    );

endmodule

// ----- rtl/sbrb_cmd_fifo.sv -----
// sbrb_cmd_fifo: short queue of drain commands between front and back.
// Depends on sbrb_pkg (QUEUE_DEPTH).

module sbrb_cmd_fifo #(
    parameter int DATA_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              nonempty
);
    import sbrb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/sbrb_front.sv -----
// sbrb_front: accepts commands, does fill bookkeeping and overrun counting,
// writes samples and block stamps, queues drain commands. Depends on sbrb_pkg.

module sbrb_front #(
    parameter int BLOCK_WORDS = sbrb_pkg::DEF_BLOCK_WORDS,
    parameter int NUM_BLOCKS  = sbrb_pkg::DEF_NUM_BLOCKS,
    localparam int BI_W = $clog2(NUM_BLOCKS),
    localparam int WI_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  sbrb_pkg::op_t                 op,
    input  logic [sbrb_pkg::SAMPLE_W-1:0] sample,
    output logic                          swr_en,
    output logic [BI_W+WI_W-1:0]          swr_addr,
    output logic [sbrb_pkg::SAMPLE_W-1:0] swr_data,
    output logic                          lwr_en,
    output logic [BI_W-1:0]               lwr_addr,
    output logic [sbrb_pkg::LOST_W-1:0]   lwr_data,
    output logic                          q_push,
    output logic                          q_empty,
    output logic [BI_W-1:0]               q_blk,
    input  logic                          q_full,
    input  logic                          blk_free
);
    import sbrb_pkg::*;

    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(NUM_BLOCKS);
    localparam logic [BI_W-1:0]  BLK_LAST = BI_W'(NUM_BLOCKS - 1);
    localparam logic [WI_W-1:0]  LVL_LAST = WI_W'(BLOCK_WORDS - 1);

    logic [BI_W-1:0]   fill_idx_reg, fill_idx_next;
    logic [BI_W-1:0]   drain_idx_reg, drain_idx_next;
    logic [CNT_W-1:0]  avail_reg, avail_next;   // committed, not yet claimed
    logic [CNT_W-1:0]  occ_reg, occ_next;       // committed, not yet freed
    logic [WI_W-1:0]   level_reg, level_next;
    logic              filling_reg, filling_next;
    logic [LOST_W-1:0] pending_reg, pending_next;

    logic is_push, starting, have_free, phys_free, push_wait, accept;
    logic push_store, commit;

    assign is_push   = (op == OP_PUSH);
    assign starting  = !filling_reg;
    assign have_free = (avail_reg < CNT_MAX);
    assign phys_free = (occ_reg < CNT_MAX);
    // block still being read out by the back end
    assign push_wait = starting && have_free && !phys_free;
    assign cmd_stall = is_push ? push_wait : q_full;
    assign accept    = cmd_valid && !cmd_stall;

    assign push_store = accept && is_push && (!starting || have_free);
    assign commit     = push_store && (level_reg == LVL_LAST);

    assign swr_en   = push_store;
    assign swr_addr = {fill_idx_reg, level_reg};
    assign swr_data = sample;
    assign lwr_en   = push_store && starting;
    assign lwr_addr = fill_idx_reg;
    assign lwr_data = pending_reg;

    assign q_push  = accept && !is_push;
    assign q_empty = (avail_reg == '0);
    assign q_blk   = drain_idx_reg;

    always_comb
    begin
        fill_idx_next  = fill_idx_reg;
        drain_idx_next = drain_idx_reg;
        avail_next     = avail_reg;
        occ_next       = occ_reg;
        level_next     = level_reg;
        filling_next   = filling_reg;
        pending_next   = pending_reg;

        if (accept && is_push && starting && !have_free)
        begin
            if (pending_reg != LOST_MAX)
            begin
                pending_next = pending_reg + 1'b1;
            end
        end

        if (push_store)
        begin
            if (commit)
            begin
                fill_idx_next = (fill_idx_reg == BLK_LAST) ? '0 : fill_idx_reg + 1'b1;
                filling_next  = 1'b0;
                level_next    = '0;
                pending_next  = '0;
            end
            else
            begin
                filling_next = 1'b1;
                level_next   = level_reg + 1'b1;
            end
        end

        if (q_push && !q_empty)
        begin
            drain_idx_next = (drain_idx_reg == BLK_LAST) ? '0 : drain_idx_reg + 1'b1;
        end

        avail_next = avail_reg + CNT_W'(commit) - CNT_W'(q_push && !q_empty);
        occ_next   = occ_reg + CNT_W'(commit) - CNT_W'(blk_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg  <= '0;
            drain_idx_reg <= '0;
            avail_reg     <= '0;
            occ_reg       <= '0;
            level_reg     <= '0;
            filling_reg   <= 1'b0;
            pending_reg   <= '0;
        end
        else
        begin
            fill_idx_reg  <= fill_idx_next;
            drain_idx_reg <= drain_idx_next;
            avail_reg     <= avail_next;
            occ_reg       <= occ_next;
            level_reg     <= level_next;
            filling_reg   <= filling_next;
            pending_reg   <= pending_next;
        end
    end

    a_avail_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
        avail_reg <= occ_reg)
        else $error("committed count exceeds occupied count");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_MAX)
        else $error("occupied count beyond ring size");

    a_free_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        blk_free |-> (occ_reg > avail_reg))
        else $error("block freed that was never claimed");

endmodule

// ----- rtl/sbrb_back.sv -----
// sbrb_back: sample and stamp memories, drain sequencer and result register.
// Depends on sbrb_pkg.

module sbrb_back #(
    parameter int BLOCK_WORDS = sbrb_pkg::DEF_BLOCK_WORDS,
    parameter int NUM_BLOCKS  = sbrb_pkg::DEF_NUM_BLOCKS,
    localparam int BI_W = $clog2(NUM_BLOCKS),
    localparam int WI_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          swr_en,
    input  logic [BI_W+WI_W-1:0]          swr_addr,
    input  logic [sbrb_pkg::SAMPLE_W-1:0] swr_data,
    input  logic                          lwr_en,
    input  logic [BI_W-1:0]               lwr_addr,
    input  logic [sbrb_pkg::LOST_W-1:0]   lwr_data,
    input  logic                          q_nonempty,
    input  logic                          q_empty,
    input  logic [BI_W-1:0]               q_blk,
    output logic                          q_pop,
    output logic                          blk_free,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [sbrb_pkg::SAMPLE_W-1:0] word,
    output logic [sbrb_pkg::COUNT_W-1:0]  word_count,
    output logic [sbrb_pkg::LOST_W-1:0]   lost_samples,
    output logic                          empty_res,
    output logic                          last
);
    import sbrb_pkg::*;

    localparam int MEM_DEPTH = NUM_BLOCKS << WI_W;
    localparam logic [WI_W-1:0]    LVL_LAST = WI_W'(BLOCK_WORDS - 1);
    localparam logic [COUNT_W-1:0] WCOUNT   = COUNT_W'(BLOCK_WORDS);

    typedef enum logic [1:0]
    {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } state_t;

    logic [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
    logic [LOST_W-1:0]   lost_mem [NUM_BLOCKS];

    state_t            state_reg, state_next;
    logic [BI_W-1:0]   blk_reg, blk_next;
    logic [WI_W-1:0]   k_reg, k_next;
    logic              valid_reg, valid_next;
    logic              empty_reg, empty_next;
    logic              last_reg, last_next;
    logic [SAMPLE_W-1:0] word_reg;
    logic [LOST_W-1:0]   lost_reg;

    logic            out_load, issue, issue_empty, rd_en, last_word;
    logic [BI_W-1:0] cur_blk;
    logic [WI_W-1:0] cur_k;

    assign out_load = !valid_reg || !res_stall;

    always_comb
    begin
        issue       = 1'b0;
        issue_empty = 1'b0;
        cur_blk     = blk_reg;
        cur_k       = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                issue       = q_nonempty;
                issue_empty = q_empty;
                cur_blk     = q_blk;
                cur_k       = '0;
            end
            S_STREAM:
            begin
                issue = 1'b1;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign last_word = (cur_k == LVL_LAST);
    assign q_pop     = out_load && (state_reg == S_IDLE) && q_nonempty;
    assign rd_en     = out_load && issue && !issue_empty;
    assign blk_free  = rd_en && last_word;

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        k_next     = k_reg;
        valid_next = valid_reg;
        empty_next = empty_reg;
        last_next  = last_reg;
        if (out_load)
        begin
            valid_next = issue;
            empty_next = issue_empty;
            last_next  = issue_empty || last_word;
            if (rd_en && !last_word)
            begin
                state_next = S_STREAM;
                blk_next   = cur_blk;
                k_next     = cur_k + 1'b1;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            blk_reg   <= '0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
            empty_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg   <= blk_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
            empty_reg <= empty_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (swr_en)
        begin
            sample_mem[swr_addr] <= swr_data;
        end
        if (rd_en)
        begin
            word_reg <= sample_mem[{cur_blk, cur_k}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lwr_en)
        begin
            lost_mem[lwr_addr] <= lwr_data;
        end
        if (rd_en)
        begin
            lost_reg <= lost_mem[cur_blk];
        end
    end

    assign res_valid    = valid_reg;
    assign empty_res    = empty_reg;
    assign last         = last_reg;
    assign word         = empty_reg ? '0 : word_reg;
    assign lost_samples = empty_reg ? '0 : lost_reg;
    assign word_count   = empty_reg ? '0 : WCOUNT;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && empty_reg) |-> last_reg)
        else $error("empty result not marked last");

    a_stream_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STREAM) |-> valid_reg)
        else $error("streaming with no result held");

    a_free_then_last: assert property (@(posedge clk) disable iff (!rst_n)
        blk_free |=> (valid_reg && last_reg && !empty_reg))
        else $error("block freed without its final word");

endmodule
